/* src/anchor_trilateration_unit_assert.svh */
// Assertion macros used by the trilateration unit RTL.
// No dependencies; include with the bare file name.
`ifndef ANCHOR_TRILATERATION_UNIT_ASSERT_SVH
`define ANCHOR_TRILATERATION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ATU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/atu_pkg.sv */
// Types and constants of the anchor trilateration unit.
// No dependencies; used by every module of the unit.
package atu_pkg;

  localparam int NumAnchors = 4;
  localparam int FrontStages = 5;
  localparam int LaneStages = 16;
  localparam int NumStages = FrontStages + LaneStages + 1;
  localparam int CfgIdxW = 3;
  localparam int CoordW = 14;
  localparam int NumW = 45;
  localparam int DenW = 32;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [15:0] pos_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_DEGEN     = 2'd1,
    STATUS_BAD_COUNT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_TRI  = 2'd1,
    MODE_SQ   = 2'd2
  } mode_e;

  typedef struct packed {
    logic [2:0] anchor_count;
    logic [1:0] first_anchor;
    logic [1:0] second_anchor;
    logic [1:0] third_anchor;
    logic [9:0] dist_a0;
    logic [9:0] dist_a1;
    logic [9:0] dist_a2;
    logic [9:0] dist_a3;
  } req_t;

  typedef struct packed {
    pos_t    pos_x;
    pos_t    pos_y;
    status_e status;
  } rsp_t;

  // Reset layout: a square of side 1000 cm with anchor 0 at the origin.
  localparam coord_t CfgResetX [NumAnchors] = '{14'sd0, 14'sd0, 14'sd1000, 14'sd1000};
  localparam coord_t CfgResetY [NumAnchors] = '{14'sd0, 14'sd1000, 14'sd0, 14'sd1000};

endpackage

/* src/atu_front.sv */
// Front end of the trilateration unit: anchor selection, squares, linear
// system setup and numerators and the shared divisor for both lanes. Uses atu_pkg.
module atu_front (
  input  logic                             clk_i,
  input  logic [atu_pkg::FrontStages-1:0]  en_i,
  input  atu_pkg::req_t                    req_i,
  input  atu_pkg::coord_t                  anc_x_i [atu_pkg::NumAnchors],
  input  atu_pkg::coord_t                  anc_y_i [atu_pkg::NumAnchors],
  output logic signed [atu_pkg::NumW-1:0]  num_x_o,
  output logic signed [atu_pkg::NumW-1:0]  num_y_o,
  output logic signed [atu_pkg::DenW-1:0]  den_o,
  output logic                             byp_o,
  output atu_pkg::pos_t                    pass_x_o,
  output atu_pkg::pos_t                    pass_y_o,
  output atu_pkg::status_e                 status_o
);

  // ---- stage 1: select anchors, differences, trivial modes
  atu_pkg::mode_e   mode1_d, mode1_q;
  atu_pkg::status_e st1_d, st1_q;
  atu_pkg::pos_t    px1_d, px1_q, py1_d, py1_q;
  logic signed [14:0] a1_d, a1_q, b1_d, b1_q, c1_d, c1_q, e1_d, e1_q;
  logic [1:0] i0_q, i1_q, i2_q;
  logic [9:0] dist1_q [atu_pkg::NumAnchors];
  atu_pkg::coord_t side1_q;

  logic signed [14:0] sum_x, sum_y, mid_x, mid_y;
  atu_pkg::coord_t ax0, ay0, ax1, ay1, ax2, ay2;

  always_comb begin
    ax0 = anc_x_i[req_i.first_anchor];
    ay0 = anc_y_i[req_i.first_anchor];
    ax1 = anc_x_i[req_i.second_anchor];
    ay1 = anc_y_i[req_i.second_anchor];
    ax2 = anc_x_i[req_i.third_anchor];
    ay2 = anc_y_i[req_i.third_anchor];
    a1_d = 15'(ax0) - 15'(ax2);
    b1_d = 15'(ay0) - 15'(ay2);
    c1_d = 15'(ax1) - 15'(ax2);
    e1_d = 15'(ay1) - 15'(ay2);
    sum_x = 15'(ax0) + 15'(ax1);
    sum_y = 15'(ay0) + 15'(ay1);
    // round the halved sum toward zero
    mid_x = (sum_x + $signed({14'd0, sum_x[14]})) >>> 1;
    mid_y = (sum_y + $signed({14'd0, sum_y[14]})) >>> 1;
    mode1_d = atu_pkg::MODE_PASS;
    st1_d = atu_pkg::STATUS_OK;
    px1_d = '0;
    py1_d = '0;
    unique case (req_i.anchor_count)
      3'd1: begin
        px1_d = 16'(ax0);
        py1_d = 16'(ay0);
      end
      3'd2: begin
        px1_d = 16'(mid_x);
        py1_d = 16'(mid_y);
      end
      3'd3: mode1_d = atu_pkg::MODE_TRI;
      3'd4: begin
        if (anc_x_i[3] == '0) begin
          st1_d = atu_pkg::STATUS_DEGEN;
        end else begin
          mode1_d = atu_pkg::MODE_SQ;
        end
      end
      default: st1_d = atu_pkg::STATUS_BAD_COUNT;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mode1_q <= mode1_d;
      st1_q <= st1_d;
      px1_q <= px1_d;
      py1_q <= py1_d;
      a1_q <= a1_d;
      b1_q <= b1_d;
      c1_q <= c1_d;
      e1_q <= e1_d;
      i0_q <= req_i.first_anchor;
      i1_q <= req_i.second_anchor;
      i2_q <= req_i.third_anchor;
      dist1_q[0] <= req_i.dist_a0;
      dist1_q[1] <= req_i.dist_a1;
      dist1_q[2] <= req_i.dist_a2;
      dist1_q[3] <= req_i.dist_a3;
      side1_q <= anc_x_i[3];
    end
  end

  // ---- stage 2: products and squares
  atu_pkg::mode_e   mode2_q;
  atu_pkg::status_e st2_q;
  atu_pkg::pos_t    px2_q, py2_q;
  logic signed [14:0] a2_q, b2_q, c2_q, e2_q;
  logic [1:0] i0_2_q, i1_2_q, i2_2_q;
  atu_pkg::coord_t side2_q;
  logic signed [29:0] pe2_q, pb2_q;
  logic signed [28:0] dsq2_q [atu_pkg::NumAnchors];
  logic signed [28:0] nrm2_q [atu_pkg::NumAnchors];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mode2_q <= mode1_q;
      st2_q <= st1_q;
      px2_q <= px1_q;
      py2_q <= py1_q;
      a2_q <= a1_q;
      b2_q <= b1_q;
      c2_q <= c1_q;
      e2_q <= e1_q;
      i0_2_q <= i0_q;
      i1_2_q <= i1_q;
      i2_2_q <= i2_q;
      side2_q <= side1_q;
      pe2_q <= 30'(a1_q) * 30'(e1_q);
      pb2_q <= 30'(b1_q) * 30'(c1_q);
      for (int k = 0; k < atu_pkg::NumAnchors; k++) begin
        dsq2_q[k] <= $signed(29'(dist1_q[k]) * 29'(dist1_q[k]));
        nrm2_q[k] <= 29'(anc_x_i[k]) * 29'(anc_x_i[k])
                   + 29'(anc_y_i[k]) * 29'(anc_y_i[k]);
      end
    end
  end

  // ---- stage 3: determinant, right-hand sides, square-layout sums
  atu_pkg::mode_e   mode3_d, mode3_q;
  atu_pkg::status_e st3_d, st3_q;
  atu_pkg::pos_t    px3_q, py3_q;
  logic signed [14:0] a3_q, b3_q, c3_q, e3_q;
  atu_pkg::coord_t side3_q;
  logic signed [30:0] det3_d, det3_q, nx3_d, nx3_q, ny3_d, ny3_q;
  logic signed [28:0] r0_d, r0_q, r1_d, r1_q;
  logic signed [28:0] rhs [3];

  always_comb begin
    det3_d = 31'(pe2_q) - 31'(pb2_q);
    r0_d = dsq2_q[i2_2_q] - dsq2_q[i0_2_q] + nrm2_q[i0_2_q] - nrm2_q[i2_2_q];
    r1_d = dsq2_q[i2_2_q] - dsq2_q[i1_2_q] + nrm2_q[i1_2_q] - nrm2_q[i2_2_q];
    for (int k = 0; k < 3; k++) begin
      rhs[k] = dsq2_q[k] - dsq2_q[3] - nrm2_q[k] + nrm2_q[3];
    end
    // least-squares weights: x row (1, 2, -1), y row (1, -1, 2)
    nx3_d = 31'(rhs[0]) + (31'(rhs[1]) <<< 1) - 31'(rhs[2]);
    ny3_d = 31'(rhs[0]) - 31'(rhs[1]) + (31'(rhs[2]) <<< 1);
    mode3_d = mode2_q;
    st3_d = st2_q;
    if (mode2_q == atu_pkg::MODE_TRI && det3_d == '0) begin
      mode3_d = atu_pkg::MODE_PASS;
      st3_d = atu_pkg::STATUS_DEGEN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      mode3_q <= mode3_d;
      st3_q <= st3_d;
      px3_q <= px2_q;
      py3_q <= py2_q;
      a3_q <= a2_q;
      b3_q <= b2_q;
      c3_q <= c2_q;
      e3_q <= e2_q;
      side3_q <= side2_q;
      det3_q <= det3_d;
      nx3_q <= nx3_d;
      ny3_q <= ny3_d;
      r0_q <= r0_d;
      r1_q <= r1_d;
    end
  end

  // ---- stage 4: Cramer products
  atu_pkg::mode_e   mode4_q;
  atu_pkg::status_e st4_q;
  atu_pkg::pos_t    px4_q, py4_q;
  atu_pkg::coord_t  side4_q;
  logic signed [30:0] det4_q, nx4_q, ny4_q;
  logic signed [43:0] er0_q, br1_q, ar1_q, cr0_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      mode4_q <= mode3_q;
      st4_q <= st3_q;
      px4_q <= px3_q;
      py4_q <= py3_q;
      side4_q <= side3_q;
      det4_q <= det3_q;
      nx4_q <= nx3_q;
      ny4_q <= ny3_q;
      er0_q <= 44'(e3_q) * 44'(r0_q);
      br1_q <= 44'(b3_q) * 44'(r1_q);
      ar1_q <= 44'(a3_q) * 44'(r1_q);
      cr0_q <= 44'(c3_q) * 44'(r0_q);
    end
  end

  // ---- stage 5: numerators and divisor
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      if (mode4_q == atu_pkg::MODE_TRI) begin
        num_x_o <= 45'(er0_q) - 45'(br1_q);
        num_y_o <= 45'(ar1_q) - 45'(cr0_q);
        den_o <= 32'(det4_q) <<< 1;
      end else begin
        num_x_o <= 45'(nx4_q);
        num_y_o <= 45'(ny4_q);
        den_o <= 32'(17'(side4_q) * 17'sd6);
      end
      byp_o <= (mode4_q == atu_pkg::MODE_PASS);
      pass_x_o <= px4_q;
      pass_y_o <= py4_q;
      status_o <= st4_q;
    end
  end

endmodule

/* src/atu_div_lane.sv */
// One coordinate lane: signed restoring division, one quotient bit per
// stage, truncation toward zero and 16-bit saturation. Uses atu_pkg.
module atu_div_lane (
  input  logic                             clk_i,
  input  logic [atu_pkg::LaneStages-1:0]   en_i,
  input  logic signed [atu_pkg::NumW-1:0]  num_i,
  input  logic signed [atu_pkg::DenW-1:0]  den_i,
  input  logic                             byp_i,
  input  atu_pkg::pos_t                    pass_i,
  output atu_pkg::pos_t                    res_o
);

  localparam int QW = atu_pkg::LaneStages - 1;
  localparam int TW = atu_pkg::NumW + 2;

  logic [atu_pkg::NumW-1:0] rem_q [atu_pkg::LaneStages];
  logic [atu_pkg::DenW-1:0] dm_q  [atu_pkg::LaneStages];
  logic [QW-1:0]            qt_q  [atu_pkg::LaneStages];
  logic                     neg_q [atu_pkg::LaneStages];
  logic                     ovf_q [atu_pkg::LaneStages];
  logic                     byp_q [atu_pkg::LaneStages];
  atu_pkg::pos_t            pass_q [atu_pkg::LaneStages];

  logic [atu_pkg::NumW-1:0] nmag;
  logic [atu_pkg::DenW-1:0] dmag;

  always_comb begin
    nmag = num_i[atu_pkg::NumW-1] ? atu_pkg::NumW'(-num_i) : atu_pkg::NumW'(num_i);
    dmag = den_i[atu_pkg::DenW-1] ? atu_pkg::DenW'(-den_i) : atu_pkg::DenW'(den_i);
  end

  // prep: magnitudes, quotient sign, overflow when |q| reaches 2^15
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= nmag;
      dm_q[0] <= dmag;
      qt_q[0] <= '0;
      neg_q[0] <= num_i[atu_pkg::NumW-1] ^ den_i[atu_pkg::DenW-1];
      ovf_q[0] <= {2'b00, nmag} >= {dmag, QW'(0)};
      byp_q[0] <= byp_i;
      pass_q[0] <= pass_i;
    end
  end

  for (genvar j = 1; j < atu_pkg::LaneStages; j++) begin : g_step
    localparam int Bit = QW - j;
    logic [TW-1:0] trial;
    logic          fits;

    always_comb begin
      trial = {2'b00, rem_q[j-1]} - (TW'(dm_q[j-1]) << Bit);
      fits = !trial[TW-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= fits ? trial[atu_pkg::NumW-1:0] : rem_q[j-1];
        qt_q[j] <= qt_q[j-1] | (QW'(fits) << Bit);
        dm_q[j] <= dm_q[j-1];
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
        byp_q[j] <= byp_q[j-1];
        pass_q[j] <= pass_q[j-1];
      end
    end
  end

  logic signed [15:0] qs;

  always_comb begin
    qs = $signed({1'b0, qt_q[QW]});
    if (byp_q[QW]) begin
      res_o = pass_q[QW];
    end else if (ovf_q[QW]) begin
      res_o = neg_q[QW] ? 16'sh8000 : 16'sh7fff;
    end else begin
      res_o = neg_q[QW] ? -qs : qs;
    end
  end

endmodule

/* src/anchor_trilateration_unit.sv */
// Anchor trilateration unit: anchor registers, pipeline flow control and
// merge of the two coordinate lanes. Uses atu_pkg, atu_front, atu_div_lane.
//
// Usage: requests arrive on req_valid_i/req_ready_o with the anchor count,
// up to three anchor indices and four distances; fixes leave on
// rsp_valid_o/rsp_ready_i as pos_x, pos_y and status. Anchor coordinates are
// written through cfg_we_i/cfg_idx_i/cfg_wdata_i (index 2k is x of anchor k,
// 2k+1 its y) while no request is in flight.
// rsp_valid_o rises once the accepted request has passed through 22 register
// stages: five setup stages, one divider prep stage, fifteen restoring steps
// (one quotient bit each) and the response register. One request is accepted
// per cycle while req_ready_o is high; the x and y dividers run as separate
// lanes in lockstep. Each stage has its own valid bit, so a stalled response
// only holds the stages behind it that are full; empty stages keep taking
// requests. Reset empties the pipeline and loads the default square layout of
// side 1000 cm with anchor 0 at the origin.
`include "anchor_trilateration_unit_assert.svh"

module anchor_trilateration_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  atu_pkg::req_t                req_i,
  output logic                         rsp_valid_o,
  input  logic                         rsp_ready_i,
  output atu_pkg::rsp_t                rsp_o,
  input  logic                         cfg_we_i,
  input  logic [atu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [atu_pkg::CoordW-1:0]   cfg_wdata_i
);

  localparam int NS = atu_pkg::NumStages;
  localparam int FS = atu_pkg::FrontStages;
  localparam int LS = atu_pkg::LaneStages;

  // ---- anchor registers
  atu_pkg::coord_t anc_x_q [atu_pkg::NumAnchors];
  atu_pkg::coord_t anc_y_q [atu_pkg::NumAnchors];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < atu_pkg::NumAnchors; k++) begin
        anc_x_q[k] <= atu_pkg::CfgResetX[k];
        anc_y_q[k] <= atu_pkg::CfgResetY[k];
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i[0]) begin
        anc_y_q[cfg_idx_i[atu_pkg::CfgIdxW-1:1]] <= $signed(cfg_wdata_i);
      end else begin
        anc_x_q[cfg_idx_i[atu_pkg::CfgIdxW-1:1]] <= $signed(cfg_wdata_i);
      end
    end
  end

  // ---- per-stage valid bits and ready chain
  logic [NS-1:0] vld_q, vld_d;
  logic [NS:0]   rdy;

  assign rdy[NS] = rsp_ready_i;
  for (genvar k = 0; k < NS; k++) begin : g_flow
    assign rdy[k] = !vld_q[k] || rdy[k+1];
    if (k == 0) begin : g_first
      assign vld_d[k] = rdy[k] ? req_valid_i : vld_q[k];
    end else begin : g_next
      assign vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign req_ready_o = rdy[0];
  assign rsp_valid_o = vld_q[NS-1];

  // ---- setup stages
  logic signed [atu_pkg::NumW-1:0] num_x, num_y;
  logic signed [atu_pkg::DenW-1:0] den;
  logic                            byp;
  atu_pkg::pos_t                   pass_x, pass_y, res_x, res_y;
  atu_pkg::status_e                st_front;

  atu_front u_front (
    .clk_i    (clk_i),
    .en_i     (rdy[FS-1:0]),
    .req_i    (req_i),
    .anc_x_i  (anc_x_q),
    .anc_y_i  (anc_y_q),
    .num_x_o  (num_x),
    .num_y_o  (num_y),
    .den_o    (den),
    .byp_o    (byp),
    .pass_x_o (pass_x),
    .pass_y_o (pass_y),
    .status_o (st_front)
  );

  // ---- coordinate lanes
  atu_div_lane u_lane_x (
    .clk_i  (clk_i),
    .en_i   (rdy[FS+LS-1:FS]),
    .num_i  (num_x),
    .den_i  (den),
    .byp_i  (byp),
    .pass_i (pass_x),
    .res_o  (res_x)
  );

  atu_div_lane u_lane_y (
    .clk_i  (clk_i),
    .en_i   (rdy[FS+LS-1:FS]),
    .num_i  (num_y),
    .den_i  (den),
    .byp_i  (byp),
    .pass_i (pass_y),
    .res_o  (res_y)
  );

  // status travels beside the lanes
  atu_pkg::status_e st_q [LS];

  for (genvar j = 0; j < LS; j++) begin : g_status
    always_ff @(posedge clk_i) begin
      if (rdy[FS+j]) begin
        st_q[j] <= (j == 0) ? st_front : st_q[(j == 0) ? 0 : j-1];
      end
    end
  end

  // ---- merge into the response register
  atu_pkg::rsp_t rsp_q;

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      rsp_q.pos_x <= res_x;
      rsp_q.pos_y <= res_y;
      rsp_q.status <= st_q[LS-1];
    end
  end

  assign rsp_o = rsp_q;

  `ATU_ASSERT_IMPL(a_bad_count_zero, clk_i, rst_ni,
    rsp_valid_o && rsp_o.status == atu_pkg::STATUS_BAD_COUNT,
    rsp_o.pos_x == '0 && rsp_o.pos_y == '0, "bad count response carries a position")
  `ATU_ASSERT_IMPL(a_degen_zero, clk_i, rst_ni,
    rsp_valid_o && rsp_o.status == atu_pkg::STATUS_DEGEN,
    rsp_o.pos_x == '0 && rsp_o.pos_y == '0, "degenerate response carries a position")
  `ATU_ASSERT_IMPL(a_stall_only_full, clk_i, rst_ni,
    !req_ready_o, vld_q[0] && rsp_valid_o && !rsp_ready_i,
    "input stalled while pipeline has room")
  `ATU_ASSERT_NEXT(a_rsp_held, clk_i, rst_ni,
    rsp_valid_o && !rsp_ready_i, rsp_valid_o && $stable(rsp_q),
    "stalled response changed inside the output register")

endmodule

/* test/fix_checker.sv */
// Position-fix checker: watches the request and response channels of the
// trilateration unit, predicts each fix and compares it. Uses atu_pkg.
`timescale 1ns / 100ps

module fix_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  logic                        req_ready_i,
  input  atu_pkg::req_t               req_i,
  input  logic                        rsp_valid_i,
  input  logic                        rsp_ready_i,
  input  atu_pkg::rsp_t               rsp_i,
  input  logic                        cfg_we_i,
  input  logic [atu_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [atu_pkg::CoordW-1:0]  cfg_wdata_i,
  output int                          fail_count_o,
  output int                          pending_fixes_o
);
  import atu_pkg::*;

  longint anchor_x [NumAnchors];
  longint anchor_y [NumAnchors];
  rsp_t   fix_queue [$];

  function automatic pos_t clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return pos_t'(v);
  endfunction

  function automatic rsp_t make_fix(longint x, longint y, status_e st);
    rsp_t r;
    r.pos_x = clamp16(x);
    r.pos_y = clamp16(y);
    r.status = st;
    return r;
  endfunction

  // Circle equation of anchor k relative to the reference anchor r.
  function automatic longint rel_term(longint d[NumAnchors], int k, int r);
    return d[r] * d[r] - d[k] * d[k] + anchor_x[k] * anchor_x[k]
         + anchor_y[k] * anchor_y[k] - anchor_x[r] * anchor_x[r]
         - anchor_y[r] * anchor_y[r];
  endfunction

  function automatic rsp_t predict_fix(req_t q);
    longint d [NumAnchors];
    longint a, b, c, e, det, r0, r1, side, t, nx, ny;
    int i0, i1, i2;
    i0 = q.first_anchor;
    i1 = q.second_anchor;
    i2 = q.third_anchor;
    d[0] = q.dist_a0;
    d[1] = q.dist_a1;
    d[2] = q.dist_a2;
    d[3] = q.dist_a3;
    case (q.anchor_count)
      3'd1: return make_fix(anchor_x[i0], anchor_y[i0], STATUS_OK);
      3'd2: return make_fix((anchor_x[i0] + anchor_x[i1]) / 2,
                            (anchor_y[i0] + anchor_y[i1]) / 2, STATUS_OK);
      3'd3: begin
        a = anchor_x[i0] - anchor_x[i2];
        b = anchor_y[i0] - anchor_y[i2];
        c = anchor_x[i1] - anchor_x[i2];
        e = anchor_y[i1] - anchor_y[i2];
        det = a * e - b * c;
        if (det == 0) return make_fix(0, 0, STATUS_DEGEN);
        r0 = rel_term(d, i0, i2);
        r1 = rel_term(d, i1, i2);
        return make_fix((e * r0 - b * r1) / (2 * det), (a * r1 - c * r0) / (2 * det),
                        STATUS_OK);
      end
      3'd4: begin
        side = anchor_x[3];
        if (side == 0) return make_fix(0, 0, STATUS_DEGEN);
        nx = 0;
        ny = 0;
        for (int k = 0; k < 3; k++) begin
          t = d[k] * d[k] - d[3] * d[3] - anchor_x[k] * anchor_x[k]
            - anchor_y[k] * anchor_y[k] + anchor_x[3] * anchor_x[3]
            + anchor_y[3] * anchor_y[3];
          // x weights 1,2,-1; y weights 1,-1,2
          nx += (k == 0) ? t : (k == 1) ? 2 * t : -t;
          ny += (k == 0) ? t : (k == 1) ? -t : 2 * t;
        end
        return make_fix(nx / (6 * side), ny / (6 * side), STATUS_OK);
      end
      default: return make_fix(0, 0, STATUS_BAD_COUNT);
    endcase
  endfunction

  assign pending_fixes_o = fix_queue.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumAnchors; k++) begin
        anchor_x[k] = CfgResetX[k];
        anchor_y[k] = CfgResetY[k];
      end
      fix_queue.delete();
      fail_count_o <= 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (fix_queue.size() == 0) begin
          $display("%0t: unexpected fix, expected none, actual %p", $time, rsp_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          rsp_t want;
          want = fix_queue.pop_front();
          if (rsp_i.pos_x !== want.pos_x || rsp_i.pos_y !== want.pos_y ||
              rsp_i.status !== want.status) begin
            $display("%0t: fix mismatch, expected x=%0d y=%0d st=%0d, actual x=%0d y=%0d st=%0d",
                     $time, want.pos_x, want.pos_y, want.status,
                     rsp_i.pos_x, rsp_i.pos_y, rsp_i.status);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (req_valid_i && req_ready_i) fix_queue.push_back(predict_fix(req_i));
      if (cfg_we_i) begin
        if (cfg_idx_i[0]) anchor_y[cfg_idx_i >> 1] = $signed(cfg_wdata_i);
        else anchor_x[cfg_idx_i >> 1] = $signed(cfg_wdata_i);
      end
    end
  end
endmodule

/* test/testbench.sv */
// Testbench top for the anchor trilateration unit: clock, reset, request
// stimulus, anchor layouts and verdict. Uses atu_pkg and fix_checker.
`timescale 1ns / 100ps

module testbench;
  import atu_pkg::*;

  localparam int Latency = 22;
  localparam longint CycleLimit = 400000;

  logic clk, rst_n;
  logic req_valid, req_ready, rsp_valid, rsp_ready, cfg_we;
  req_t req;
  rsp_t rsp;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CoordW-1:0] cfg_wdata;
  int fail_count, pending_fixes;
  int send_idle_pct, recv_idle_pct;
  longint cycles = 0;

  anchor_trilateration_unit dut (
    .clk_i(clk), .rst_ni(rst_n), .req_valid_i(req_valid), .req_ready_o(req_ready),
    .req_i(req), .rsp_valid_o(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_o(rsp),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  fix_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .req_valid_i(req_valid), .req_ready_i(req_ready),
    .req_i(req), .rsp_valid_i(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_i(rsp),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_fixes_o(pending_fixes)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(negedge clk) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

  // Leaves valid high after the accepting edge; the next request or drain drops it.
  task automatic send_fix(req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= q;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_anchor(int idx, int val);
    cfg_we <= 1'b1;
    cfg_idx <= idx[CfgIdxW-1:0];
    cfg_wdata <= val[CoordW-1:0];
    @(negedge clk);
  endtask

  task automatic drain;
    req_valid <= 1'b0;
    while (pending_fixes != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
  endtask

  function automatic req_t random_fix(bit wide);
    req_t q;
    q = req_t'($bits(req_t)'({$urandom, $urandom}));
    q.anchor_count = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                               : 3'($urandom_range(4, 1));
    if (!wide) begin
      q.dist_a0 = $urandom_range(999);
      q.dist_a1 = $urandom_range(999);
      q.dist_a2 = $urandom_range(999);
      q.dist_a3 = $urandom_range(999);
    end
    return q;
  endfunction

  function automatic int rand_coord(int mode);
    case (mode)
      0: return $urandom_range(2000) - 1000;
      1: return ($urandom_range(1)) ? 8191 : -8192;
      default: return $urandom_range(16383) - 8192;
    endcase
  endfunction

  initial begin
    req_t q;
    cycles = 0;
    rst_n = 1'b0;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    send_idle_pct = 9;
    recv_idle_pct = 50;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every count, extremes of distances and indices, repeated indices.
    for (int c = 0; c < 8; c++) begin
      q = '0;
      q.anchor_count = 3'(c);
      q.first_anchor = 2'(c);
      q.second_anchor = 2'(c + 1);
      q.third_anchor = 2'(c + 2);
      q.dist_a0 = (c[0]) ? 10'd1023 : 10'd0;
      q.dist_a1 = 10'd999;
      q.dist_a2 = (c[1]) ? 10'd0 : 10'd1023;
      q.dist_a3 = 10'd500;
      send_fix(q);
    end
    q = '1;
    q.anchor_count = 3'd3;
    send_fix(q);  // repeated indices: degenerate
    q.anchor_count = 3'd2;
    send_fix(q);
    q.anchor_count = 3'd4;
    send_fix(q);
    q = '0;
    q.anchor_count = 3'd4;
    send_fix(q);
    drain();
    // Zero side in four-anchor mode, then extreme corners.
    write_anchor(6, 0);
    cfg_we <= 1'b0;
    send_fix(q);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin
        send_idle_pct = 50;
        recv_idle_pct = 9;
      end else if (phase == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int r = 0; r < 8; r++) write_anchor(r, rand_coord(phase % 3));
      cfg_we <= 1'b0;
      for (int n = 0; n < 155; n++) send_fix(random_fix(n % 20 == 0));
      drain();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
